@@ rtl/pnv_pkg.sv @@
`default_nettype none

package pnv_pkg;

  // One input transaction: a byte of the request target
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic        number_valid;
    logic [43:0] number_bcd;
  } out_item_t;

  // Percent-escape decoder phase
  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_PCT2 = 2'd2
  } esc_phase_e;

  // Classified character handed from the front to the back.
  // All class bits are zero when the byte feeds nothing into the matcher.
  typedef struct packed {
    logic       feed;
    logic       is_dig;
    logic       is_ws;
    logic       is_base;   // '-', '.', ' '
    logic       is_lpar;
    logic       is_rpar;
    logic       is_slash;
    logic       is_plus;
    logic [3:0] digit;
    logic       fail;      // bad escape seen on this byte
    logic       esc_open;  // escape still pending after this byte
    logic       last;
  } pnv_tok_t;

  // Matcher positions
  localparam int unsigned NumPos  = 14;
  localparam int unsigned P_START = 0;
  localparam int unsigned P_LEAD  = 1;
  localparam int unsigned P_PLUS  = 2;
  localparam int unsigned P_SEP0  = 3;
  localparam int unsigned P_A1    = 4;
  localparam int unsigned P_A2    = 5;
  localparam int unsigned P_SEP1  = 6;
  localparam int unsigned P_B1    = 7;
  localparam int unsigned P_B2    = 8;
  localparam int unsigned P_SEP2  = 9;
  localparam int unsigned P_C1    = 10;
  localparam int unsigned P_C2    = 11;
  localparam int unsigned P_C3    = 12;
  localparam int unsigned P_END   = 13;

  // Number formatting
  localparam logic [3:0] CountNational = 4'd10;
  localparam logic [3:0] CountIntl     = 4'd11;
  localparam logic [3:0] CountMax      = 4'd15;
  localparam logic [3:0] CountryDflt   = 4'd7;
  localparam logic [3:0] CountryRemap  = 4'd8;

endpackage

`default_nettype wire

@@ rtl/pnv_front.sv @@
`default_nettype none

module pnv_front import pnv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  input  wire logic     push_ok_i,
  output logic          push_o,
  output pnv_tok_t      tok_o
);

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPlus  = 8'h2B;

  esc_phase_e esc_q, esc_d;
  logic       feed;
  logic       fail;
  logic [7:0] ch;

  assign push_o = in_valid_i && push_ok_i;

  // Decode percent escapes
  always_comb begin
    esc_d = esc_q;
    feed  = 1'b0;
    fail  = 1'b0;
    ch    = in_data_i.char_byte;
    case (esc_q)
      ESC_NONE: begin
        if (in_data_i.char_byte == ChPct) esc_d = ESC_PCT;
        else feed = 1'b1;
      end
      ESC_PCT: begin
        if (in_data_i.char_byte == ChTwo) begin
          esc_d = ESC_PCT2;
        end else begin
          fail  = 1'b1;
          esc_d = ESC_NONE;
        end
      end
      ESC_PCT2: begin
        if (in_data_i.char_byte == ChZero) begin
          feed = 1'b1;
          ch   = ChSpace;
        end else begin
          fail = 1'b1;
        end
        esc_d = ESC_NONE;
      end
      default: begin
        esc_d = ESC_NONE;
      end
    endcase
  end

  // Classify the decoded character
  always_comb begin
    tok_o          = '0;
    tok_o.feed     = feed;
    tok_o.is_dig   = feed && (ch >= ChZero) && (ch <= ChNine);
    tok_o.is_ws    = feed && ((ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr)));
    tok_o.is_base  = feed && ((ch == ChDash) || (ch == ChDot) || (ch == ChSpace));
    tok_o.is_lpar  = feed && (ch == ChLpar);
    tok_o.is_rpar  = feed && (ch == ChRpar);
    tok_o.is_slash = feed && (ch == ChSlash);
    tok_o.is_plus  = feed && (ch == ChPlus);
    tok_o.digit    = ch[3:0];
    tok_o.fail     = fail;
    tok_o.esc_open = (esc_d != ESC_NONE);
    tok_o.last     = in_data_i.last_byte;
  end

  // Advance escape phase; the last byte closes the target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_NONE;
    end else if (push_o) begin
      esc_q <= in_data_i.last_byte ? ESC_NONE : esc_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pnv_queue.sv @@
`default_nettype none

module pnv_queue import pnv_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire pnv_tok_t push_tok_i,
  output logic          full_o,
  output logic          head_valid_o,
  output pnv_tok_t      head_tok_o,
  input  wire logic     pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pnv_tok_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntFull);
  assign head_valid_o = (cnt_q != '0);
  assign head_tok_o   = mem_q[rd_q];

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_tok_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pnv_back.sv @@
`default_nettype none

module pnv_back import pnv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     head_valid_i,
  input  wire pnv_tok_t tok_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  logic [NumPos-1:0] pos_q, pos_d;
  logic [43:0]       store_q, store_d;
  logic [3:0]        cnt_q, cnt_d;
  logic              fail_q, fail_d;
  logic              oval_q;
  out_item_t         out_q, res;
  logic              out_free;
  logic [3:0]        country;
  logic              s0, s1, s2;

  // Pop unless a result is due and the output register cannot take it
  assign out_free = !oval_q || !out_stall_i;
  assign pop_o    = head_valid_i && (!tok_i.last || out_free);

  assign s0 = tok_i.is_base || tok_i.is_lpar;
  assign s1 = tok_i.is_base || tok_i.is_rpar;
  assign s2 = tok_i.is_base;

  // Step the position set
  always_comb begin
    pos_d = '0;
    if (tok_i.feed) begin
      if (pos_q[P_START] && tok_i.is_slash) pos_d[P_LEAD] = 1'b1;
      if (pos_q[P_LEAD]) begin
        if (tok_i.is_ws)   pos_d[P_LEAD] = 1'b1;
        if (tok_i.is_plus) pos_d[P_PLUS] = 1'b1;
        if (tok_i.is_dig) begin
          pos_d[P_SEP0] = 1'b1;
          pos_d[P_A1]   = 1'b1;
        end
        if (s0) pos_d[P_SEP0] = 1'b1;
      end
      if (pos_q[P_PLUS] && tok_i.is_dig) pos_d[P_SEP0] = 1'b1;
      if (pos_q[P_SEP0]) begin
        if (s0)           pos_d[P_SEP0] = 1'b1;
        if (tok_i.is_dig) pos_d[P_A1]   = 1'b1;
      end
      if (pos_q[P_A1] && tok_i.is_dig) pos_d[P_A2]   = 1'b1;
      if (pos_q[P_A2] && tok_i.is_dig) pos_d[P_SEP1] = 1'b1;
      if (pos_q[P_SEP1]) begin
        if (s1)           pos_d[P_SEP1] = 1'b1;
        if (tok_i.is_dig) pos_d[P_B1]   = 1'b1;
      end
      if (pos_q[P_B1] && tok_i.is_dig) pos_d[P_B2]   = 1'b1;
      if (pos_q[P_B2] && tok_i.is_dig) pos_d[P_SEP2] = 1'b1;
      if (pos_q[P_SEP2]) begin
        if (s2)           pos_d[P_SEP2] = 1'b1;
        if (tok_i.is_dig) pos_d[P_C1]   = 1'b1;
      end
      if (pos_q[P_C1] && tok_i.is_dig) pos_d[P_C2]  = 1'b1;
      if (pos_q[P_C2] && tok_i.is_dig) pos_d[P_C3]  = 1'b1;
      if (pos_q[P_C3] && tok_i.is_dig) pos_d[P_END] = 1'b1;
      if (pos_q[P_END] && tok_i.is_ws) pos_d[P_END] = 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  // Shift digits and count them
  always_comb begin
    store_d = store_q;
    cnt_d   = cnt_q;
    if (tok_i.is_dig) begin
      store_d = {store_q[39:0], tok_i.digit};
      if (cnt_q != CountMax) cnt_d = cnt_q + 1'b1;
    end
    fail_d = fail_q || tok_i.fail;
  end

  // Form the result from the updated state
  always_comb begin
    country = CountryDflt;
    if ((cnt_d == CountIntl) && (store_d[43:40] != CountryRemap)) country = store_d[43:40];
    res.number_valid = !fail_d && !tok_i.esc_open && pos_d[P_END] &&
                       ((cnt_d == CountNational) || (cnt_d == CountIntl));
    res.number_bcd   = res.number_valid ? {country, store_d[39:0]} : '0;
  end

  // Update matcher state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= NumPos'(1) << P_START;
      store_q <= '0;
      cnt_q   <= '0;
      fail_q  <= 1'b0;
    end else if (pop_o) begin
      if (tok_i.last) begin
        pos_q   <= NumPos'(1) << P_START;
        store_q <= '0;
        cnt_q   <= '0;
        fail_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        store_q <= store_d;
        cnt_q   <= cnt_d;
        fail_q  <= fail_d;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (pop_o && tok_i.last) begin
      oval_q <= 1'b1;
    end else if (!out_stall_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && tok_i.last) out_q <= res;
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/phone_number_validator_core.sv @@
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_item_t  (char_byte, last_byte)
// out      output     out_valid_o / out_stall_i  out_item_t (number_valid, number_bcd)
//
// One byte per cycle sustained unless the output stalls. A byte is decoded and
// classified in the front on the cycle it is accepted; the matcher steps one queued
// byte per cycle unless stalled and registers a target's result as its last byte pops.
// Reset puts the matcher at its start position with no escape pending.
// An output stall holds only a last byte in the queue; the input stalls once the
// queue of QueueDepth entries is full.

module phone_number_validator_core import pnv_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  logic     q_full, push, head_valid, pop;
  pnv_tok_t push_tok, head_tok;

  assign in_stall_o = q_full;

  pnv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .push_ok_i  (!q_full),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  pnv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_tok_i   (push_tok),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_tok_o   (head_tok),
    .pop_i        (pop)
  );

  pnv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .tok_i        (head_tok),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

@@ test/phone_number_validator_checker.sv @@
`timescale 1ns / 1ps

// Watch both channels, predict each target's number and compare it with the
// result transactions of the block.
module phone_number_validator_checker
  import pnv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        due_count_o
);

  // Scanner state for the target being read
  typedef struct packed {
    logic [15:0] active_pos;
    esc_phase_e  esc;
    logic [43:0] digits;
    logic [3:0]  digit_cnt;
    logic        bad_escape;
  } scan_t;

  scan_t     scan;
  out_item_t numbers_due[$];
  out_item_t want;
  out_item_t got;
  int        mismatches;

  function automatic scan_t fresh_scan();
    scan_t s;
    s = '0;
    s.esc = ESC_NONE;
    s.active_pos[P_START] = 1'b1;
    return s;
  endfunction

  // Advance the pattern positions by one decoded character
  function automatic scan_t step_pattern(scan_t s, logic [7:0] c);
    logic [15:0] cur;
    logic [15:0] nxt;
    logic        dig;
    logic        ws;
    logic        base;
    logic        sep_open;
    logic        sep_close;
    cur       = s.active_pos;
    nxt       = '0;
    dig       = (c >= "0") && (c <= "9");
    ws        = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    base      = (c == "-") || (c == ".") || (c == " ");
    sep_open  = base || (c == "(");
    sep_close = base || (c == ")");

    if (cur[P_START] && c == "/") nxt[P_LEAD] = 1'b1;
    if (cur[P_LEAD]) begin
      if (ws) nxt[P_LEAD] = 1'b1;
      if (c == "+") nxt[P_PLUS] = 1'b1;
      if (dig) begin
        nxt[P_SEP0] = 1'b1;
        nxt[P_A1]   = 1'b1;
      end
      if (sep_open) nxt[P_SEP0] = 1'b1;
    end
    if (cur[P_PLUS] && dig) nxt[P_SEP0] = 1'b1;
    if (cur[P_SEP0]) begin
      if (sep_open) nxt[P_SEP0] = 1'b1;
      if (dig) nxt[P_A1] = 1'b1;
    end
    if (cur[P_A1] && dig) nxt[P_A2] = 1'b1;
    if (cur[P_A2] && dig) nxt[P_SEP1] = 1'b1;
    if (cur[P_SEP1]) begin
      if (sep_close) nxt[P_SEP1] = 1'b1;
      if (dig) nxt[P_B1] = 1'b1;
    end
    if (cur[P_B1] && dig) nxt[P_B2] = 1'b1;
    if (cur[P_B2] && dig) nxt[P_SEP2] = 1'b1;
    if (cur[P_SEP2]) begin
      if (base) nxt[P_SEP2] = 1'b1;
      if (dig) nxt[P_C1] = 1'b1;
    end
    if (cur[P_C1] && dig) nxt[P_C2] = 1'b1;
    if (cur[P_C2] && dig) nxt[P_C3] = 1'b1;
    if (cur[P_C3] && dig) nxt[P_END] = 1'b1;
    if (cur[P_END] && ws) nxt[P_END] = 1'b1;
    s.active_pos = nxt;

    // Shift every digit into the BCD store, saturate the count
    if (dig) begin
      s.digits = {s.digits[39:0], c[3:0]};
      if (s.digit_cnt != CountMax) s.digit_cnt = s.digit_cnt + 4'd1;
    end
    return s;
  endfunction

  // Decode the percent escape, then feed the pattern
  function automatic scan_t take_byte(scan_t s, logic [7:0] c);
    case (s.esc)
      ESC_NONE: begin
        if (c == "%") s.esc = ESC_PCT;
        else s = step_pattern(s, c);
      end
      ESC_PCT: begin
        if (c == "2") begin
          s.esc = ESC_PCT2;
        end else begin
          s.bad_escape = 1'b1;
          s.esc        = ESC_NONE;
        end
      end
      default: begin
        if (c == "0") s = step_pattern(s, " ");
        else s.bad_escape = 1'b1;
        s.esc = ESC_NONE;
      end
    endcase
    return s;
  endfunction

  // Format the number reported at the end of a target
  function automatic out_item_t number_for(scan_t s);
    out_item_t  r;
    logic [3:0] country;
    r = '0;
    r.number_valid = !s.bad_escape && (s.esc == ESC_NONE) && s.active_pos[P_END] &&
                     (s.digit_cnt == CountNational || s.digit_cnt == CountIntl);
    if (r.number_valid) begin
      country = CountryDflt;
      if (s.digit_cnt == CountIntl && s.digits[43:40] != CountryRemap) begin
        country = s.digits[43:40];
      end
      r.number_bcd = {country, s.digits[39:0]};
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan = fresh_scan();
      numbers_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      // Compare a result transaction with the oldest expected number
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (numbers_due.size() == 0) begin
          $error("unexpected result: number_valid %0d number_bcd %h",
                 got.number_valid, got.number_bcd);
          mismatches++;
        end else begin
          want = numbers_due.pop_front();
          if (got.number_valid !== want.number_valid) begin
            $error("number_valid: expected %0d, actual %0d",
                   want.number_valid, got.number_valid);
            mismatches++;
          end
          if (got.number_bcd !== want.number_bcd) begin
            $error("number_bcd: expected %h, actual %h", want.number_bcd, got.number_bcd);
            mismatches++;
          end
        end
      end

      // Advance the scanner on each accepted byte; queue a number on the last one
      if (in_valid_i && !in_stall_i) begin
        scan = take_byte(scan, in_data_i.char_byte);
        if (in_data_i.last_byte) begin
          numbers_due.push_back(number_for(scan));
          scan = fresh_scan();
        end
      end

      fail_count_o <= mismatches;
      due_count_o  <= numbers_due.size();
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pnv_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int DrainLimit  = 5000;
  localparam int PhaseBytes  = 250;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;
  int        fail_count;
  int        due_count;

  int         idle_pct     = 0;
  int         stall_pct    = 0;
  bit         hold_request = 1'b0;
  int         sent_bytes   = 0;
  logic [7:0] target_q[$];

  phone_number_validator_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  phone_number_validator_checker number_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stall results at random; on request hold off for a long stretch
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(logic [7:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{char_byte: c, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_target();
    foreach (target_q[i]) send_byte(target_q[i], i == target_q.size() - 1);
  endtask

  task automatic send_text(string s);
    target_q = {};
    for (int i = 0; i < s.len(); i++) target_q.push_back(s[i]);
    send_target();
  endtask

  // Drop valid and wait until every expected number has come back
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (due_count != 0) $error("%0d results never arrived", due_count);
  endtask

  // Append a character; encode some spaces as %20
  task automatic put_char(logic [7:0] c);
    if (c == " " && $urandom_range(3) == 0) begin
      target_q.push_back("%");
      target_q.push_back("2");
      target_q.push_back("0");
    end else begin
      target_q.push_back(c);
    end
  endtask

  task automatic put_run(string set, int most);
    int n;
    n = $urandom_range(most);
    repeat (n) put_char(set[$urandom_range(set.len() - 1)]);
  endtask

  task automatic put_digits(int n);
    logic [7:0] d;
    repeat (n) begin
      d = 8'(8'h30 + $urandom_range(9));
      target_q.push_back(d);
    end
  endtask

  // Build a well-formed target with random spacing, separators and digits
  task automatic build_number();
    target_q = {};
    target_q.push_back("/");
    put_run("\011\012\013\014\015 ", 2);
    case ($urandom_range(2))
      1: begin
        target_q.push_back("+");
        if ($urandom_range(3) == 0) target_q.push_back("8");
        else put_digits(1);
      end
      2: put_digits(1);
      default: ;
    endcase
    put_run(" -.(", 2);
    put_digits(3);
    put_run(" -.)", 2);
    put_digits(3);
    put_run(" -.", 2);
    put_digits(4);
    put_run("\011\012\013\014\015 ", 2);
  endtask

  // Damage a well-formed target in one place
  task automatic break_number();
    int         pos;
    logic [7:0] b;
    pos = $urandom_range(target_q.size() - 1);
    b   = 8'($urandom_range(255));
    case ($urandom_range(5))
      0: target_q[pos] = b;
      1: if (target_q.size() > 1) target_q.delete(pos);
      2: target_q.insert(pos, b);
      3: begin
        target_q.insert(pos, "%");
        target_q.insert(pos + 1, b);
      end
      4: begin
        target_q.push_back("%");
        if ($urandom_range(1)) target_q.push_back("2");
      end
      default: begin
        b = 8'(8'h30 + $urandom_range(9));
        target_q.insert(pos, b);
      end
    endcase
  endtask

  task automatic build_noise();
    string      picks;
    logic [7:0] b;
    int         n;
    picks = "/+-.() %20123456789\011";
    n = $urandom_range(1, 12);
    target_q = {};
    repeat (n) begin
      if ($urandom_range(3) == 0) b = picks[$urandom_range(picks.len() - 1)];
      else b = 8'($urandom_range(255));
      target_q.push_back(b);
    end
  endtask

  initial begin
    int phase_start;
    int pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, cut and bad escapes, 8 remapped, no country digit
    target_q = {8'h00};
    send_target();
    target_q = {8'hFF};
    send_target();
    send_text("%");
    send_text("%2");
    send_text("%4");
    send_text("/+85551234567");
    send_text("/5551234567");
    wait_drained();

    // Random targets under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct     = 0;
          stall_pct    = 0;
          hold_request = 1'b1;
        end
        1: begin
          idle_pct  = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct  = 30;
          stall_pct = 30;
        end
      endcase
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PhaseBytes) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          build_number();
        end else if (pick < 85) begin
          build_number();
          break_number();
        end else begin
          build_noise();
        end
        send_target();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("phone_number_validator_core: match");
    end else begin
      $display("phone_number_validator_core: mismatch");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #5_000_000;
    $display("phone_number_validator_core: mismatch");
    $finish;
  end

endmodule
